// ----- rtl/core/irsz_pkg.sv -----
// ----------------------------------------------------------------------------
// irsz_pkg
// shared widths, register indexes, mode codes and control structs of the
// image resize interpolator
// ----------------------------------------------------------------------------
package irsz_pkg;

	// default parameter values
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int DEF_FRAC_BITS  = 16;

	// fixed field widths
	localparam int O_W       = 12;              // output row / column
	localparam int ISZ_W     = 7;               // source size registers
	localparam int OSZ_W     = 13;              // output size registers
	localparam int A_W       = O_W + 1 + ISZ_W + 1; // signed mapping numerator
	localparam int D_W       = OSZ_W + 1;       // mapping denominator
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int VW_MARGIN = 8;               // headroom of the cubic datapath

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_HEIGHT  = 3'd0,
		REG_IN_WIDTH   = 3'd1,
		REG_OUT_HEIGHT = 3'd2,
		REG_OUT_WIDTH  = 3'd3,
		REG_SAMPLE     = 3'd4,
		REG_COORD_MAP  = 3'd5,
		REG_ROUND      = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		SM_NEAREST  = 2'd0,
		SM_BILINEAR = 2'd1,
		SM_BICUBIC  = 2'd2
	} sample_mode_t;

	typedef enum logic [1:0] {
		CM_HALF    = 2'd0,
		CM_ASYM    = 2'd1,
		CM_ALIGN   = 2'd2,
		CM_PYTORCH = 2'd3
	} coord_map_t;

	typedef enum logic [1:0] {
		RM_FLOOR     = 2'd0,
		RM_CEIL      = 2'd1,
		RM_HALF_DOWN = 2'd2,
		RM_HALF_AWAY = 2'd3
	} round_mode_t;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// command to the interpolation engine
	typedef struct packed {
		logic start;
		logic lin;
	} eng_cmd_t;

endpackage

// ----- rtl/core/image_resize_interpolator.sv -----
// ----------------------------------------------------------------------------
// image_resize_interpolator
// resizes one image plane held in an on-chip pixel store: load words write
// source pixels, compute words return one nearest, bilinear or bicubic sample
// ----------------------------------------------------------------------------
// A load word writes the pixel store (loads outside the store are
// dropped). A compute word runs one item at a time: both output
// coordinates are mapped through two bit-serial dividers, then the
// neighbour pixels are read one per cycle from the single read port of
// the store and fed row by row to a shared multiply/add engine. Bicubic
// makes sixteen store reads and a horner pass per row plus a column pass.
// Input words are accepted again as soon as the result sits in the output
// register. The pixel store must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module image_resize_interpolator #(
	parameter int MAX_HEIGHT = irsz_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = irsz_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = irsz_pkg::DEF_PIXEL_BITS,
	parameter int FRAC_BITS  = irsz_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [irsz_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irsz_pkg::CFG_W-1:0]    cfg_data,
	// input words
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [irsz_pkg::O_W-1:0]      row,
	input  logic [irsz_pkg::O_W-1:0]      col,
	input  logic signed [PIXEL_BITS-1:0]  pixel,
	// result words
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [PIXEL_BITS-1:0]  value,
	output logic                          clipped
);

	localparam int O_W   = irsz_pkg::O_W;
	localparam int ISZ_W = irsz_pkg::ISZ_W;
	localparam int OSZ_W = irsz_pkg::OSZ_W;
	localparam int A_W   = irsz_pkg::A_W;
	localparam int D_W   = irsz_pkg::D_W;
	localparam int NUM_W = A_W - 1 + FRAC_BITS;     // divider magnitude
	localparam int CW    = NUM_W + 1;               // signed source coordinate
	localparam int IPW   = CW - FRAC_BITS;          // integer part
	localparam int BW    = IPW + 1;                 // integer part plus offset
	localparam int VW    = PIXEL_BITS + FRAC_BITS + irsz_pkg::VW_MARGIN;
	localparam int V2    = VW + 1 - FRAC_BITS;      // rounded result
	localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	localparam logic signed [V2-1:0] PIX_MAX = V2'({1'b0, {(PIXEL_BITS-1){1'b1}}});
	localparam logic signed [V2-1:0] PIX_MIN = -PIX_MAX - V2'(1);
	localparam logic [FRAC_BITS-1:0] HALF    = {1'b1, {(FRAC_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_SETUP, S_START, S_DIV, S_IDX, S_RD, S_RW, S_EST, S_ENG, S_FIN
	} state_t;

	// configuration registers
	logic [ISZ_W-1:0] in_height_q, in_width_q;
	logic [OSZ_W-1:0] out_height_q, out_width_q;
	logic [1:0]       sample_mode_q, coord_map_q, round_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= ISZ_W'(1);
			in_width_q    <= ISZ_W'(1);
			out_height_q  <= OSZ_W'(1);
			out_width_q   <= OSZ_W'(1);
			sample_mode_q <= irsz_pkg::SM_NEAREST;
			coord_map_q   <= irsz_pkg::CM_HALF;
			round_mode_q  <= irsz_pkg::RM_FLOOR;
		end else if (cfg_we) begin
			case (irsz_pkg::reg_idx_t'(cfg_index))
				irsz_pkg::REG_IN_HEIGHT:  in_height_q   <= cfg_data[ISZ_W-1:0];
				irsz_pkg::REG_IN_WIDTH:   in_width_q    <= cfg_data[ISZ_W-1:0];
				irsz_pkg::REG_OUT_HEIGHT: out_height_q  <= cfg_data[OSZ_W-1:0];
				irsz_pkg::REG_OUT_WIDTH:  out_width_q   <= cfg_data[OSZ_W-1:0];
				irsz_pkg::REG_SAMPLE:     sample_mode_q <= cfg_data[1:0];
				irsz_pkg::REG_COORD_MAP:  coord_map_q   <= cfg_data[1:0];
				irsz_pkg::REG_ROUND:      round_mode_q  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// effective sizes: zero acts as one, source sizes cap at the store
	logic [ISZ_W-1:0] isz [2];
	logic [OSZ_W-1:0] osz [2];
	logic             is_bilin, is_bicub, is_near;
	logic [1:0]       kmax;

	always_comb begin
		isz[0] = (in_height_q == '0) ? ISZ_W'(1) :
			(32'(in_height_q) > MAX_HEIGHT) ? ISZ_W'(MAX_HEIGHT) : in_height_q;
		isz[1] = (in_width_q == '0) ? ISZ_W'(1) :
			(32'(in_width_q) > MAX_WIDTH) ? ISZ_W'(MAX_WIDTH) : in_width_q;
		osz[0] = (out_height_q == '0) ? OSZ_W'(1) : out_height_q;
		osz[1] = (out_width_q == '0) ? OSZ_W'(1) : out_width_q;
		is_bilin = (sample_mode_q == irsz_pkg::SM_BILINEAR);
		is_bicub = (sample_mode_q == irsz_pkg::SM_BICUBIC);
		is_near  = !is_bilin && !is_bicub;
		kmax     = is_bicub ? 2'd3 : (is_bilin ? 2'd1 : 2'd0);
	end

	state_t state_q;
	logic [1:0] j_q, k_q;
	logic       col_pass_q;
	logic       rd_vld_q;
	logic [1:0] rd_k_q;
	logic       out_valid_q;
	logic signed [PIXEL_BITS-1:0] value_q;
	logic       clipped_q;

	logic in_acc, load_we, ram_re, out_load;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// ---- pixel store ----
	logic [AW-1:0]         waddr, raddr;
	logic [PIXEL_BITS-1:0] ram_rdata;

	assign load_we = in_acc && (action == irsz_pkg::ACT_LOAD) &&
		(32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
	assign waddr   = AW'(AW'(YW'(row)) * AW'(MAX_WIDTH)) + AW'(XW'(col));
	assign ram_re  = (state_q == S_RD);

	irsz_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (waddr),
		.wdata (pixel),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// ---- coordinate mapping setup, one axis per lane (0 rows, 1 columns) ----
	logic [O_W-1:0]          o_q [2];
	logic signed [A_W-1:0]   anum_q [2];
	logic [D_W-1:0]          den_q [2];
	logic                    byp_q [2];
	logic                    zero_q [2];
	logic signed [A_W-1:0]   anum_n [2];
	logic [D_W-1:0]          den_n [2];
	logic                    byp_n [2];
	logic                    zero_n [2];
	logic [A_W-2:0]          prod_half [2];
	logic [A_W-2:0]          prod_asym [2];
	logic [A_W-2:0]          prod_align [2];

	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			prod_half[ax]  = (A_W-1)'({o_q[ax], 1'b1}) * (A_W-1)'(isz[ax]);
			prod_asym[ax]  = (A_W-1)'(o_q[ax]) * (A_W-1)'(isz[ax]);
			prod_align[ax] = (A_W-1)'(o_q[ax]) * (A_W-1)'(isz[ax] - ISZ_W'(1));
			byp_n[ax]  = (OSZ_W'(isz[ax]) == osz[ax]);
			zero_n[ax] = ((coord_map_q == irsz_pkg::CM_ALIGN) ||
				(coord_map_q == irsz_pkg::CM_PYTORCH)) && (osz[ax] == OSZ_W'(1));
			case (coord_map_q)
				irsz_pkg::CM_ASYM: begin
					anum_n[ax] = $signed({1'b0, prod_asym[ax]});
					den_n[ax]  = D_W'(osz[ax]);
				end
				irsz_pkg::CM_ALIGN: begin
					anum_n[ax] = $signed({1'b0, prod_align[ax]});
					den_n[ax]  = D_W'(osz[ax] - OSZ_W'(1));
				end
				default: begin
					// half pixel and pytorch half pixel
					anum_n[ax] = $signed({1'b0, prod_half[ax]}) - $signed(A_W'(osz[ax]));
					den_n[ax]  = {osz[ax], 1'b0};
				end
			endcase
		end
	end

	// ---- dividers ----
	logic                  dv_start;
	logic                  dv_done [2];
	logic signed [CW-1:0]  dv_quo [2];
	logic [A_W-1:0]        anum_abs [2];

	assign dv_start = (state_q == S_START);

	for (genvar ax = 0; ax < 2; ax++) begin : g_div
		assign anum_abs[ax] = anum_q[ax][A_W-1] ? A_W'(-anum_q[ax]) : A_W'(anum_q[ax]);
		irsz_div #(
			.NW (NUM_W),
			.DW (D_W)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (dv_start),
			.neg    (anum_q[ax][A_W-1]),
			.mag    ({anum_abs[ax][A_W-2:0], {FRAC_BITS{1'b0}}}),
			.den    (den_q[ax]),
			.done   (dv_done[ax]),
			.quo    (dv_quo[ax])
		);
	end

	// ---- source coordinate, index base and fraction ----
	logic signed [CW-1:0]   c_q [2];
	logic signed [CW-1:0]   c_n [2];
	logic signed [BW-1:0]   base_q [2];
	logic signed [BW-1:0]   base_n [2];
	logic [FRAC_BITS-1:0]   frac_q [2];
	logic signed [BW-1:0]   fl_b [2];
	logic [FRAC_BITS-1:0]   frac_n [2];
	logic                   inc [2];

	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			if (byp_q[ax]) begin
				c_n[ax] = CW'({o_q[ax], {FRAC_BITS{1'b0}}});
			end else if (zero_q[ax]) begin
				c_n[ax] = '0;
			end else begin
				c_n[ax] = dv_quo[ax];
			end
			fl_b[ax]   = BW'($signed(c_q[ax][CW-1:FRAC_BITS]));
			frac_n[ax] = c_q[ax][FRAC_BITS-1:0];
			case (round_mode_q)
				irsz_pkg::RM_CEIL:      inc[ax] = (frac_n[ax] != '0);
				irsz_pkg::RM_HALF_DOWN: inc[ax] = (frac_n[ax] > HALF);
				irsz_pkg::RM_HALF_AWAY: inc[ax] = c_q[ax][CW-1] ? (frac_n[ax] > HALF) :
					(frac_n[ax] >= HALF);
				default:                inc[ax] = 1'b0;
			endcase
			if (is_near) begin
				base_n[ax] = fl_b[ax] + $signed({{(BW-1){1'b0}}, inc[ax]});
			end else if (is_bicub) begin
				base_n[ax] = fl_b[ax] + $signed({BW{1'b1}});
			end else begin
				base_n[ax] = fl_b[ax];
			end
		end
	end

	// edge clamp of a neighbour index
	function automatic logic [ISZ_W-1:0] clampi(input logic signed [BW-1:0] v,
		input logic [ISZ_W-1:0] sz);
		if (v < 0) begin
			return '0;
		end else if (v >= $signed(BW'(sz))) begin
			return sz - ISZ_W'(1);
		end else begin
			return v[ISZ_W-1:0];
		end
	endfunction

	logic [YW-1:0] rd_row;
	logic [XW-1:0] rd_col;

	assign rd_row = YW'(clampi(base_q[0] + BW'($signed({1'b0, j_q})), isz[0]));
	assign rd_col = XW'(clampi(base_q[1] + BW'($signed({1'b0, k_q})), isz[1]));
	assign raddr  = AW'(AW'(rd_row) * AW'(MAX_WIDTH)) + AW'(rd_col);

	// ---- interpolation engine ----
	logic signed [PIXEL_BITS-1:0] p_q [4];
	logic signed [VW-1:0]         rows_q [4];
	logic signed [VW-1:0]         eng_p [4];
	irsz_pkg::eng_cmd_t           eng_cmd;
	logic                         eng_done;
	logic signed [VW-1:0]         eng_res;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			eng_p[i] = col_pass_q ? rows_q[i] : (VW'(p_q[i]) <<< FRAC_BITS);
		end
		eng_cmd.start = (state_q == S_EST);
		eng_cmd.lin   = is_bilin;
	end

	irsz_horner #(
		.VW        (VW),
		.FRAC_BITS (FRAC_BITS)
	) u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (eng_cmd),
		.p      (eng_p),
		.t      (col_pass_q ? frac_q[0] : frac_q[1]),
		.done   (eng_done),
		.res    (eng_res)
	);

	// ---- final rounding half up and saturation ----
	logic signed [VW:0]           rsum;
	logic signed [V2-1:0]         rv;
	logic signed [PIXEL_BITS-1:0] fin_value;
	logic                         fin_clip;

	always_comb begin
		rsum = (VW+1)'(eng_res) + $signed((VW+1)'(HALF));
		rv   = V2'(rsum >>> FRAC_BITS);
		if (is_near) begin
			fin_value = p_q[0];
			fin_clip  = 1'b0;
		end else if (rv > PIX_MAX) begin
			fin_value = PIX_MAX[PIXEL_BITS-1:0];
			fin_clip  = 1'b1;
		end else if (rv < PIX_MIN) begin
			fin_value = PIX_MIN[PIXEL_BITS-1:0];
			fin_clip  = 1'b1;
		end else begin
			fin_value = rv[PIXEL_BITS-1:0];
			fin_clip  = 1'b0;
		end
	end

	// ---- sequencer and output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			k_q         <= '0;
			col_pass_q  <= 1'b0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			clipped_q   <= 1'b0;
		end else begin
			rd_vld_q <= ram_re;
			if (out_load) begin
				out_valid_q <= 1'b1;
				value_q     <= fin_value;
				clipped_q   <= fin_clip;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && action == irsz_pkg::ACT_COMPUTE) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (dv_done[0]) begin
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					j_q        <= '0;
					k_q        <= '0;
					col_pass_q <= 1'b0;
					state_q    <= S_RD;
				end
				S_RD: begin
					// one store read per cycle across the current row
					if (k_q == kmax) begin
						k_q     <= '0;
						state_q <= S_RW;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_RW: state_q <= is_near ? S_FIN : S_EST;
				S_EST: state_q <= S_ENG;
				S_ENG: begin
					if (eng_done) begin
						if (col_pass_q) begin
							state_q <= S_FIN;
						end else if (j_q == kmax) begin
							// all rows done, run the column pass on their results
							col_pass_q <= 1'b1;
							state_q    <= S_EST;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			o_q[0] <= row;
			o_q[1] <= col;
		end
		if (state_q == S_SETUP) begin
			anum_q <= anum_n;
			den_q  <= den_n;
			byp_q  <= byp_n;
			zero_q <= zero_n;
		end
		if (state_q == S_DIV && dv_done[0]) begin
			c_q <= c_n;
		end
		if (state_q == S_IDX) begin
			base_q <= base_n;
			frac_q <= frac_n;
		end
		if (ram_re) begin
			rd_k_q <= k_q;
		end
		if (rd_vld_q) begin
			p_q[rd_k_q] <= $signed(ram_rdata);
		end
		if (state_q == S_ENG && eng_done && !col_pass_q) begin
			rows_q[j_q] <= eng_res;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign clipped   = clipped_q;

	// ---- assertions ----
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done[0] == dv_done[1])
		else $error("row and column dividers finished apart");

	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_we && ram_re))
		else $error("store written while being sampled");

	a_eng_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> (state_q == S_ENG))
		else $error("engine result arrived outside the engine wait");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("finished result not presented");

endmodule

// ----- rtl/core/irsz_ram.sv -----
// ----------------------------------------------------------------------------
// irsz_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module irsz_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/irsz_div.sv -----
// ----------------------------------------------------------------------------
// irsz_div
// restoring divider, one quotient bit a cycle, signed result floored
// ----------------------------------------------------------------------------
module irsz_div #(
	parameter int NW = 36,
	parameter int DW = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              neg,
	input  logic [NW-1:0]     mag,
	input  logic [DW-1:0]     den,
	output logic              done,
	output logic signed [NW:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic [NW-1:0]   qn_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     rem_sh;
	logic            qbit;
	logic [DW:0]     rem_sub;

	always_comb begin
		rem_sh  = {rem_q, qn_q[NW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg;
			qn_q  <= mag;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			qn_q  <= {qn_q[NW-2:0], qbit};
			rem_q <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	// negative numerator: floor means one more in magnitude on a remainder
	always_comb begin
		if (!neg_q) begin
			quo = $signed({1'b0, qn_q});
		end else if (rem_q != '0) begin
			quo = -$signed({1'b0, qn_q}) - (NW+1)'(1);
		end else begin
			quo = -$signed({1'b0, qn_q});
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/core/irsz_horner.sv -----
// ----------------------------------------------------------------------------
// irsz_horner
// interpolation engine: catmull-rom cubic by horner steps on one shared
// multiplier, or a single linear step
// ----------------------------------------------------------------------------
module irsz_horner #(
	parameter int VW        = 40,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  irsz_pkg::eng_cmd_t     cmd,
	input  logic signed [VW-1:0]   p [4],
	input  logic [FRAC_BITS-1:0]   t,
	output logic                   done,
	output logic signed [VW-1:0]   res
);

	localparam int PW = VW + FRAC_BITS + 1;

	typedef enum logic [1:0] {E_IDLE, E_COEF, E_MUL, E_ADD} est_t;

	est_t                   st_q;
	logic [1:0]             step_q;
	logic                   lin_q;
	logic                   done_q;
	logic signed [VW-1:0]   res_q;
	logic signed [VW-1:0]   pv_q [4];
	logic [FRAC_BITS-1:0]   t_q;
	logic signed [VW-1:0]   h_q;
	logic signed [VW-1:0]   coef_q [3];
	logic signed [PW-1:0]   prod_q;
	logic signed [VW-1:0]   a2, b2, c2, d2, hn;

	// doubled catmull-rom coefficients
	always_comb begin
		a2 = -pv_q[0] + (pv_q[1] <<< 1) + pv_q[1] - (pv_q[2] <<< 1) - pv_q[2] + pv_q[3];
		b2 = (pv_q[0] <<< 1) - (pv_q[1] <<< 2) - pv_q[1] + (pv_q[2] <<< 2) - pv_q[3];
		c2 = pv_q[2] - pv_q[0];
		d2 = pv_q[1] <<< 1;
		hn = VW'(prod_q >>> FRAC_BITS) + coef_q[step_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			step_q <= '0;
			lin_q  <= 1'b0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				E_IDLE: begin
					if (cmd.start) begin
						lin_q <= cmd.lin;
						st_q  <= E_COEF;
					end
				end
				E_COEF: begin
					step_q <= '0;
					st_q   <= E_MUL;
				end
				E_MUL: begin
					st_q <= E_ADD;
				end
				E_ADD: begin
					if (lin_q || step_q == 2'd2) begin
						res_q  <= lin_q ? hn : (hn >>> 1);
						done_q <= 1'b1;
						st_q   <= E_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
						st_q   <= E_MUL;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			E_IDLE: begin
				if (cmd.start) begin
					pv_q <= p;
					t_q  <= t;
				end
			end
			E_COEF: begin
				if (lin_q) begin
					h_q       <= pv_q[1] - pv_q[0];
					coef_q[0] <= pv_q[0];
				end else begin
					h_q       <= a2;
					coef_q[0] <= b2;
					coef_q[1] <= c2;
					coef_q[2] <= d2;
				end
			end
			E_MUL: begin
				prod_q <= PW'(h_q) * PW'($signed({1'b0, t_q}));
			end
			E_ADD: begin
				h_q <= hn;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- sim/image_resize_interpolator_tb.sv -----
// ----------------------------------------------------------------------------
// image_resize_interpolator_tb
// self-checking bench: loads source pixels and runs compute words under
// directed and random register settings, predicts each output pixel in
// fixed point and compares it with the block's result words
// ----------------------------------------------------------------------------
module image_resize_interpolator_tb;

	localparam longint ONE_Q      = 64'sd1 << irsz_pkg::DEF_FRAC_BITS;
	localparam int     STORE_H    = irsz_pkg::DEF_MAX_HEIGHT;
	localparam int     STORE_W    = irsz_pkg::DEF_MAX_WIDTH;
	localparam int     O_W        = irsz_pkg::O_W;
	localparam int     ISZ_W      = irsz_pkg::ISZ_W;
	localparam int     OSZ_W      = irsz_pkg::OSZ_W;
	localparam int     CFG_W      = irsz_pkg::CFG_W;
	localparam int     CFG_IDX_W  = irsz_pkg::CFG_IDX_W;
	localparam int     SETTLE     = 200;   // cycles after the last result
	localparam int     HANG_LIMIT = 5000;  // cycles with no word accepted

	typedef struct {
		logic                 act;
		logic [O_W-1:0]       r;
		logic [O_W-1:0]       c;
		logic signed [15:0]   pix;
	} pix_word_t;

	typedef struct {
		logic signed [15:0] v;
		logic               clip;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = irsz_pkg::ACT_LOAD;
	logic [O_W-1:0] row = '0;
	logic [O_W-1:0] col = '0;
	logic signed [15:0] pixel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] value;
	logic clipped;

	image_resize_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .row(row), .col(col), .pixel(pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .clipped(clipped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// words waiting for the driver, samples waiting for the block
	pix_word_t pending_words[$];
	sample_t   expected_samples[$];
	int        errors = 0;
	bit        calm = 0;     // no idling in the last part of the run

	// predictor copy of the registers and the pixel store
	logic [ISZ_W-1:0] img_h = 1, img_w = 1;
	logic [OSZ_W-1:0] res_h = 1, res_w = 1;
	logic [1:0] smode = irsz_pkg::SM_NEAREST;
	logic [1:0] cmap = irsz_pkg::CM_HALF;
	logic [1:0] rmode = irsz_pkg::RM_FLOOR;
	logic signed [15:0] img_mem [0:STORE_H*STORE_W-1];
	bit loaded [0:STORE_H*STORE_W-1];

	function automatic longint fdiv(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint src_size(logic [ISZ_W-1:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic longint dst_size(logic [OSZ_W-1:0] v);
		return (v == 0) ? 1 : v;
	endfunction

	// output coordinate to source coordinate in Q.16
	function automatic longint map_pos(longint o, longint isz, longint osz);
		if (isz == osz)
			return o * ONE_Q;
		case (cmap)
			irsz_pkg::CM_ASYM: return fdiv(o * isz * ONE_Q, osz);
			irsz_pkg::CM_ALIGN: begin
				if (osz == 1) return 0;
				return fdiv(o * (isz - 1) * ONE_Q, osz - 1);
			end
			irsz_pkg::CM_PYTORCH: begin
				if (osz == 1) return 0;
				return fdiv(((2 * o + 1) * isz - osz) * ONE_Q, 2 * osz);
			end
			default: return fdiv(((2 * o + 1) * isz - osz) * ONE_Q, 2 * osz);
		endcase
	endfunction

	function automatic longint clamp_idx(longint i, longint isz);
		if (i < 0) return 0;
		if (i > isz - 1) return isz - 1;
		return i;
	endfunction

	function automatic longint near_index(longint cq, longint isz);
		longint half, fl, frac, r;
		half = ONE_Q / 2;
		fl = fdiv(cq, ONE_Q);
		frac = cq - fl * ONE_Q;
		case (rmode)
			irsz_pkg::RM_CEIL: r = fdiv(cq + ONE_Q - 1, ONE_Q);
			irsz_pkg::RM_HALF_DOWN: r = (frac == half) ? fl : fdiv(cq + half, ONE_Q);
			irsz_pkg::RM_HALF_AWAY:
				r = (cq >= 0) ? fdiv(cq + half, ONE_Q) : -fdiv(half - cq, ONE_Q);
			default: r = fl;
		endcase
		return clamp_idx(r, isz);
	endfunction

	function automatic longint img_at(longint r, longint c);
		return img_mem[r * STORE_W + c];
	endfunction

	// catmull-rom horner on doubled coefficients, result in the scale of p
	function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
			longint t);
		longint a2, b2, c2, d2, h;
		a2 = -p0 + 3 * p1 - 3 * p2 + p3;
		b2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c2 = p2 - p0;
		d2 = 2 * p1;
		h = fdiv(a2 * t, ONE_Q) + b2;
		h = fdiv(h * t, ONE_Q) + c2;
		h = fdiv(h * t, ONE_Q) + d2;
		return fdiv(h, 2);
	endfunction

	function automatic sample_t resample(logic [O_W-1:0] orow, logic [O_W-1:0] ocol);
		sample_t s;
		longint ih, iw, cy, cx, y0, x0, fy, fx, v, ya, yb, xa, xb, top, bot, yc;
		longint line_res [4];
		longint q [4];
		ih = src_size(img_h, STORE_H);
		iw = src_size(img_w, STORE_W);
		cy = map_pos(orow, ih, dst_size(res_h));
		cx = map_pos(ocol, iw, dst_size(res_w));
		y0 = fdiv(cy, ONE_Q);
		fy = cy - y0 * ONE_Q;
		x0 = fdiv(cx, ONE_Q);
		fx = cx - x0 * ONE_Q;
		s.clip = 1'b0;
		if (smode == irsz_pkg::SM_BILINEAR) begin
			ya = clamp_idx(y0, ih);
			yb = clamp_idx(y0 + 1, ih);
			xa = clamp_idx(x0, iw);
			xb = clamp_idx(x0 + 1, iw);
			top = img_at(ya, xa) * (ONE_Q - fx) + img_at(ya, xb) * fx;
			bot = img_at(yb, xa) * (ONE_Q - fx) + img_at(yb, xb) * fx;
			v = fdiv(fdiv(top * (ONE_Q - fy) + bot * fy, ONE_Q) + ONE_Q / 2, ONE_Q);
		end else if (smode == irsz_pkg::SM_BICUBIC) begin
			for (int j = 0; j < 4; j++) begin
				yc = clamp_idx(y0 - 1 + j, ih);
				for (int k = 0; k < 4; k++)
					q[k] = img_at(yc, clamp_idx(x0 - 1 + k, iw)) * ONE_Q;
				line_res[j] = catmull(q[0], q[1], q[2], q[3], fx);
			end
			v = fdiv(catmull(line_res[0], line_res[1], line_res[2], line_res[3], fy)
				+ ONE_Q / 2, ONE_Q);
		end else begin
			// nearest and the unused mode code
			v = img_at(near_index(cy, ih), near_index(cx, iw));
		end
		if (v > 32767) begin
			v = 32767;
			s.clip = 1'b1;
		end
		if (v < -32768) begin
			v = -32768;
			s.clip = 1'b1;
		end
		s.v = v[15:0];
		return s;
	endfunction

	// driver: takes the next word once the current one is accepted, with gap bursts
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		pix_word_t w;
		bit fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				if (action == irsz_pkg::ACT_LOAD) begin
					if (row < STORE_H && col < STORE_W)
						img_mem[row * STORE_W + col] = pixel;
				end else begin
					expected_samples.push_back(resample(row, col));
				end
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 17);
			end
			if (!in_valid || fire) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					action <= w.act;
					row <= w.r;
					col <= w.c;
					pixel <= w.pix;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready with stall bursts
	int recv_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			recv_stall = $urandom_range(1, 17) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: each result word against the oldest predicted sample
	always @(posedge clk) begin
		sample_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				errors++;
				$display("%0t: result word with no sample expected: value %0d clipped %0b",
					$time, value, clipped);
			end else begin
				e = expected_samples.pop_front();
				if (value !== e.v) begin
					errors++;
					$display("%0t: value mismatch: expected %0d actual %0d",
						$time, e.v, value);
				end
				if (clipped !== e.clip) begin
					errors++;
					$display("%0t: clipped mismatch: expected %0b actual %0b",
						$time, e.clip, clipped);
				end
			end
		end
	end

	// watchdog on cycles with no accepted word on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_word(logic act, int r, int c, int p);
		pix_word_t w;
		w.act = act;
		w.r = O_W'(r);
		w.c = O_W'(c);
		w.pix = 16'(p);
		if (act == irsz_pkg::ACT_LOAD && r < STORE_H && c < STORE_W)
			loaded[r * STORE_W + c] = 1;
		pending_words.push_back(w);
	endtask

	// wait until the block is idle, then write all seven registers
	task automatic set_regs(int ih, int iw, int oh, int ow, int sm, int cm, int rm);
		logic [CFG_W-1:0] vals [7];
		while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
			@(posedge clk);
		vals[irsz_pkg::REG_IN_HEIGHT] = CFG_W'(ih);
		vals[irsz_pkg::REG_IN_WIDTH] = CFG_W'(iw);
		vals[irsz_pkg::REG_OUT_HEIGHT] = CFG_W'(oh);
		vals[irsz_pkg::REG_OUT_WIDTH] = CFG_W'(ow);
		vals[irsz_pkg::REG_SAMPLE] = CFG_W'(sm);
		vals[irsz_pkg::REG_COORD_MAP] = CFG_W'(cm);
		vals[irsz_pkg::REG_ROUND] = CFG_W'(rm);
		img_h = vals[irsz_pkg::REG_IN_HEIGHT][ISZ_W-1:0];
		img_w = vals[irsz_pkg::REG_IN_WIDTH][ISZ_W-1:0];
		res_h = vals[irsz_pkg::REG_OUT_HEIGHT][OSZ_W-1:0];
		res_w = vals[irsz_pkg::REG_OUT_WIDTH][OSZ_W-1:0];
		smode = vals[irsz_pkg::REG_SAMPLE][1:0];
		cmap = vals[irsz_pkg::REG_COORD_MAP][1:0];
		rmode = vals[irsz_pkg::REG_ROUND][1:0];
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// fill the region in use; checkerboard of extremes drives bicubic overshoot
	task automatic fill_region(bit extremes, bit only_missing);
		int ih, iw;
		ih = src_size(img_h, STORE_H);
		iw = src_size(img_w, STORE_W);
		for (int r = 0; r < ih; r++)
			for (int c = 0; c < iw; c++)
				if (!only_missing || !loaded[r * STORE_W + c])
					push_word(irsz_pkg::ACT_LOAD, r, c,
						extremes ? (((r + c) & 1) ? 32767 : -32768)
						: $urandom_range(0, 65535));
	endtask

	task automatic corner_points();
		push_word(irsz_pkg::ACT_COMPUTE, 0, 0, $urandom_range(0, 65535));
		push_word(irsz_pkg::ACT_COMPUTE, 4095, 4095, 0);
		push_word(irsz_pkg::ACT_COMPUTE, 1, 2, 16'h7fff);
		push_word(irsz_pkg::ACT_COMPUTE, 2, 4095, 16'h8000);
	endtask

	function automatic int pick_in_size();
		case ($urandom_range(0, 39))
			0: return 0;
			1: return 64;
			2: return $urandom_range(65, 127);
			3: return $urandom_range(9, 63);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int pick_out_size();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 4096;
			2: return 8191;
			3: return $urandom_range(17, 4095);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	int ocol_lim, orow_lim;
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each mode, map and rounding, size extremes, overshoot
		set_regs(4, 4, 7, 3, irsz_pkg::SM_NEAREST, irsz_pkg::CM_HALF, irsz_pkg::RM_FLOOR);
		fill_region(1, 0);
		corner_points();
		for (int m = irsz_pkg::RM_CEIL; m <= irsz_pkg::RM_HALF_AWAY; m++) begin
			set_regs(4, 4, 8, 8, irsz_pkg::SM_NEAREST, irsz_pkg::CM_HALF, m);
			push_word(irsz_pkg::ACT_COMPUTE, 3, 5, 0);
			push_word(irsz_pkg::ACT_COMPUTE, 4095, 0, 0);
		end
		set_regs(4, 4, 1, 1, irsz_pkg::SM_BILINEAR, irsz_pkg::CM_ALIGN, irsz_pkg::RM_FLOOR);
		corner_points();
		set_regs(4, 4, 9, 5, irsz_pkg::SM_BICUBIC, irsz_pkg::CM_ASYM, irsz_pkg::RM_FLOOR);
		corner_points();
		set_regs(4, 4, 1, 0, irsz_pkg::SM_BICUBIC, irsz_pkg::CM_PYTORCH, irsz_pkg::RM_FLOOR);
		push_word(irsz_pkg::ACT_COMPUTE, 0, 1, 0);
		push_word(irsz_pkg::ACT_LOAD, 64, 4095, 1234);     // outside the store, dropped
		set_regs(127, 0, 8191, 4096, 3, irsz_pkg::CM_HALF, irsz_pkg::RM_HALF_AWAY);
		fill_region(0, 1);
		push_word(irsz_pkg::ACT_LOAD, 4095, 63, -1);
		corner_points();

		// random phases, mostly small images and output sizes
		for (int ph = 0; ph < 18; ph++) begin
			if (ph == 15) calm = 1;
			set_regs(pick_in_size(), pick_in_size(), pick_out_size(), pick_out_size(),
				$urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
			fill_region($urandom_range(0, 4) == 0, $urandom_range(0, 1));
			orow_lim = (res_h == 0) ? 0 : res_h - 1;
			ocol_lim = (res_w == 0) ? 0 : res_w - 1;
			for (int n = 0; n < 30; n++) begin
				case ($urandom_range(0, 9))
					0: push_word(irsz_pkg::ACT_LOAD, $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 65535));
					1: push_word(irsz_pkg::ACT_LOAD,
						$urandom_range(0, src_size(img_h, STORE_H) - 1),
						$urandom_range(0, src_size(img_w, STORE_W) - 1),
						$urandom_range(0, 65535));
					2: push_word(irsz_pkg::ACT_COMPUTE, $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(0, 65535));
					default: push_word(irsz_pkg::ACT_COMPUTE,
						$urandom_range(0, orow_lim > 4095 ? 4095 : orow_lim),
						$urandom_range(0, ocol_lim > 4095 ? 4095 : ocol_lim),
						$urandom_range(0, 65535));
				endcase
			end
		end

		while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
